FILE: rtl/core/gcd_pkg.sv
`timescale 1ns / 1ps

package gcd_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int LIN_FRAC      = 8;
  // 255^2.2 stays below 2^18
  localparam int LIN_W         = 18 + LIN_FRAC;
  localparam int PAIR_W        = LIN_W + 1;
  localparam int SUM_W         = LIN_W + 2;
  localparam int CFG_W         = 12;
  localparam int HEIGHT_LIMIT  = 2048;
  localparam int Q_DEPTH       = 4;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef logic [LIN_W-1:0] lin_t;
  typedef lin_t lin_tab_t [256];

  // one finished 2x2 block waiting for the gamma search
  typedef struct packed {
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [7:0]       alpha;
    logic [2:0]       cnt;
    logic             eor;
    logic             eof;
  } blk_t;

  // line buffer word: top-row pair sums
  typedef struct packed {
    logic [PAIR_W-1:0] r;
    logic [PAIR_W-1:0] g;
    logic [PAIR_W-1:0] b;
    logic [8:0]        a;
    logic [1:0]        cnt;
  } pair_t;

  // largest y with y^5 <= v^11 * 2^(5*frac), worked out at elaboration
  function automatic lin_tab_t build_lin();
    lin_tab_t     t;
    logic [191:0] tgt;
    logic [191:0] tr;
    lin_t         y;
    lin_t         c;
    for (int v = 0; v < 256; v++) begin
      tgt = 192'd1;
      for (int k = 0; k < 11; k++) tgt = tgt * 192'(v);
      tgt = tgt << (5 * LIN_FRAC);
      y = '0;
      for (int bt = LIN_W - 1; bt >= 0; bt--) begin
        c  = y | (LIN_W'(1) << bt);
        tr = 192'd1;
        for (int k = 0; k < 5; k++) tr = tr * 192'(c);
        if (tr <= tgt) y = c;
      end
      t[v] = y;
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();

endpackage

FILE: rtl/core/gcd_ram.sv
`timescale 1ns / 1ps

module gcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gcd_fifo.sv
`timescale 1ns / 1ps

module gcd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gcd_pkg::blk_t  push_data,
  output logic           room,
  input  logic           pop,
  output logic           not_empty,
  output gcd_pkg::blk_t  head
);

  localparam int PW = $clog2(gcd_pkg::Q_DEPTH);

  gcd_pkg::blk_t mem_r [gcd_pkg::Q_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  // room for the item now in the adder stage plus one more
  assign room      = (cnt_r + (PW + 1)'(push)) < (PW + 1)'(gcd_pkg::Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: rtl/core/gcd_front.sv
`timescale 1ns / 1ps

module gcd_front #(
  parameter int MAX_WIDTH = gcd_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [gcd_pkg::CFG_W-1:0] width_cfg,
  input  logic [gcd_pkg::CFG_W-1:0] height_cfg,
  input  logic                     in_valid,
  input  logic [31:0]              in_data,
  input  logic                     room,
  output logic                     in_ready,
  output logic                     push,
  output gcd_pkg::blk_t            push_data
);

  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int AW  = $clog2(PAIR_DEPTH);
  localparam int CW  = $clog2(MAX_WIDTH) + 1;
  localparam int EW  = (CW > gcd_pkg::CFG_W) ? CW : gcd_pkg::CFG_W;
  localparam int RW  = gcd_pkg::CFG_W;
  localparam int LW  = gcd_pkg::LIN_W;
  localparam int PW  = gcd_pkg::PAIR_W;
  localparam int SW  = gcd_pkg::SUM_W;

  typedef enum logic [1:0] {K_NONE, K_LEFT, K_TOP, K_BOT} kind_t;

  logic [EW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [EW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [EW-1:0] w_raw;
  logic [EW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          accept;
  logic          in_region;
  kind_t         kind;
  logic [7:0]    a_in;
  gcd_pkg::lin_t lr, lg, lb;
  logic          last_col, last_row;

  logic [LW-1:0] held_r_r, held_g_r, held_b_r;
  logic [7:0]    held_a_r;

  kind_t         s1_kind_r;
  logic [LW-1:0] s1_r_r, s1_g_r, s1_b_r;
  logic [7:0]    s1_a_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_eor_r, s1_eof_r;

  gcd_pkg::pair_t top_word, cur_pair;
  logic [SW-1:0]  sr, sg, sb;
  logic [9:0]     sa;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;
  assign a_in     = in_data[31:24];

  always_comb begin
    w_raw = EW'(width_cfg);
    if (w_raw > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else if (w_raw == '0)       w_eff = EW'(1);
    else                        w_eff = w_raw;
    if (height_cfg > RW'(gcd_pkg::HEIGHT_LIMIT)) h_eff = RW'(gcd_pkg::HEIGHT_LIMIT);
    else if (height_cfg == '0)                   h_eff = RW'(1);
    else                                         h_eff = height_cfg;
  end

  always_comb begin
    in_region = ((col_r >> 1) < (w_eff >> 1)) && ((row_r >> 1) < (h_eff >> 1));
    if (!in_region)      kind = K_NONE;
    else if (!col_r[0])  kind = K_LEFT;
    else if (!row_r[0])  kind = K_TOP;
    else                 kind = K_BOT;
    last_col = (col_r >> 1) + EW'(1) == (w_eff >> 1);
    last_row = (row_r >> 1) + RW'(1) == (h_eff >> 1);
  end

  always_comb begin
    lr = (a_in != 8'd0) ? gcd_pkg::LIN_TAB[in_data[7:0]]   : '0;
    lg = (a_in != 8'd0) ? gcd_pkg::LIN_TAB[in_data[15:8]]  : '0;
    lb = (a_in != 8'd0) ? gcd_pkg::LIN_TAB[in_data[23:16]] : '0;
  end

  always_comb begin
    col_inc = {1'b0, col_r} + (EW + 1)'(1);
    row_inc = {1'b0, row_r} + (RW + 1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= {1'b0, w_eff}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[EW-1:0];
      if (row_r >= h_eff) row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_kind_r <= K_NONE;
      held_r_r  <= '0;
      held_g_r  <= '0;
      held_b_r  <= '0;
      held_a_r  <= '0;
    end else begin
      s1_kind_r <= accept ? kind : K_NONE;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (kind == K_LEFT) begin
          held_r_r <= lr;
          held_g_r <= lg;
          held_b_r <= lb;
          held_a_r <= a_in;
        end
      end
    end
    if (accept) begin
      s1_r_r    <= lr;
      s1_g_r    <= lg;
      s1_b_r    <= lb;
      s1_a_r    <= a_in;
      s1_addr_r <= AW'(col_r >> 1);
      s1_eor_r  <= last_col;
      s1_eof_r  <= last_col && last_row;
    end
  end

  // pair sum of the right pixel with the held left one
  always_comb begin
    cur_pair.r   = PW'(held_r_r) + PW'(s1_r_r);
    cur_pair.g   = PW'(held_g_r) + PW'(s1_g_r);
    cur_pair.b   = PW'(held_b_r) + PW'(s1_b_r);
    cur_pair.a   = 9'(held_a_r) + 9'(s1_a_r);
    cur_pair.cnt = 2'(held_a_r != 8'd0) + 2'(s1_a_r != 8'd0);
  end

  gcd_ram #(
    .WIDTH ($bits(gcd_pkg::pair_t)),
    .DEPTH (PAIR_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_kind_r == K_TOP),
    .waddr (s1_addr_r),
    .wdata (cur_pair),
    .re    (accept && kind == K_BOT),
    .raddr (AW'(col_r >> 1)),
    .rdata (top_word)
  );

  always_comb begin
    sr = SW'(cur_pair.r) + SW'(top_word.r);
    sg = SW'(cur_pair.g) + SW'(top_word.g);
    sb = SW'(cur_pair.b) + SW'(top_word.b);
    sa = 10'(cur_pair.a) + 10'(top_word.a);
    push              = s1_kind_r == K_BOT;
    push_data.sum_r   = sr;
    push_data.sum_g   = sg;
    push_data.sum_b   = sb;
    push_data.alpha   = sa[9:2];
    push_data.cnt     = 3'(cur_pair.cnt) + 3'(top_word.cnt);
    push_data.eor     = s1_eor_r;
    push_data.eof     = s1_eof_r;
  end

endmodule

FILE: rtl/core/gcd_back.sv
`timescale 1ns / 1ps

module gcd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          not_empty,
  input  gcd_pkg::blk_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_data,
  output logic          out_eor,
  output logic          out_eof
);

  localparam int SW = gcd_pkg::SUM_W;
  localparam int MW = gcd_pkg::LIN_W + 3;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_DONE} state_t;

  state_t        state_r;
  gcd_pkg::blk_t blk_r;
  logic [2:0]    bit_r;
  logic [7:0]    br_r, bg_r, bb_r;
  logic [7:0]    cr, cg, cb;
  logic [MW-1:0] pr, pg, pb;

  assign pop = (state_r == S_IDLE) && not_empty;

  // n * LIN(candidate) <= sum is the same test as LIN(candidate) <= sum / n
  always_comb begin
    cr = br_r | (8'd1 << bit_r);
    cg = bg_r | (8'd1 << bit_r);
    cb = bb_r | (8'd1 << bit_r);
    pr = MW'(gcd_pkg::LIN_TAB[cr]) * MW'(blk_r.cnt);
    pg = MW'(gcd_pkg::LIN_TAB[cg]) * MW'(blk_r.cnt);
    pb = MW'(gcd_pkg::LIN_TAB[cb]) * MW'(blk_r.cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (not_empty) begin
            blk_r   <= head;
            bit_r   <= 3'd7;
            br_r    <= '0;
            bg_r    <= '0;
            bb_r    <= '0;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (blk_r.cnt != 3'd0) begin
            if (pr <= MW'(blk_r.sum_r)) br_r <= cr;
            if (pg <= MW'(blk_r.sum_g)) bg_r <= cg;
            if (pb <= MW'(blk_r.sum_b)) bb_r <= cb;
          end
          bit_r <= bit_r - 3'd1;
          if (bit_r == 3'd0) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = state_r == S_DONE;
  assign out_data  = {blk_r.alpha, bb_r, bg_r, br_r};
  assign out_eor   = blk_r.eor;
  assign out_eof   = blk_r.eof;

endmodule

FILE: rtl/core/gamma_correct_rgba_downsample_2x2.sv
`timescale 1ns / 1ps

// 2x2 box downsampler for a raster-order rgba8 stream, averaging color in
// linear light (v^2.2 with 8 fraction bits); only pixels with nonzero alpha
// count toward color, an all-transparent block is black, alpha is the plain
// four-pixel sum over four. One result per complete 2x2 block, issued after
// its bottom-right pixel; an odd last column or row is swallowed. The front
// end takes one pixel per clock while the block queue has room, into an
// adder path with a line buffer of top-row pair sums; the back end finds
// each output byte by an 8-step search of the gamma table, then hands the
// result off, and a 4-deep block queue decouples the two. The search unit
// takes no new block before its last result is handed off, so on odd rows
// it sets the pace. Sizes are written through the cfg port between frames;
// the line buffer needs no clearing.

module gamma_correct_rgba_downsample_2x2 #(
  parameter int MAX_WIDTH = gcd_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // config: index 0 src_width, index 1 src_height
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [gcd_pkg::CFG_W-1:0] cfg_wdata,
  // source pixels
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // red, green, blue, alpha
  // downsampled pixels
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                      out_tlast,  // end_of_row
  output logic                      out_tuser   // end_of_frame
);

  logic [gcd_pkg::CFG_W-1:0] width_r, height_r;
  logic                      push, pop, room, not_empty;
  gcd_pkg::blk_t             push_data, head;

  // size registers, reset to the largest frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gcd_pkg::CFG_W'(2048);
      height_r <= gcd_pkg::CFG_W'(2048);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gcd_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        gcd_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pixel intake, pair sums and line buffer
  gcd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .in_valid   (in_tvalid),
    .in_data    (in_tdata),
    .room       (room),
    .in_ready   (in_tready),
    .push       (push),
    .push_data  (push_data)
  );

  // finished block sums waiting for the search unit
  gcd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .room      (room),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // inverse gamma search and output register
  gcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_eor   (out_tlast),
    .out_eof   (out_tuser)
  );

endmodule
